FILE: rtl/indexed_sequence_store_macros.svh
// assertion macros shared by the checker
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ISI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isi check failed");

// next-cycle implication, disabled during reset
`define ISI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isi check failed");

`endif

FILE: rtl/isi_pkg.sv
package isi_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 10;
   localparam int LEN_W  = 9;

   // request kinds
   localparam logic [2:0] KIND_READ       = 3'd0;
   localparam logic [2:0] KIND_INS_FRONT  = 3'd1;
   localparam logic [2:0] KIND_APPEND     = 3'd2;
   localparam logic [2:0] KIND_INS_BEFORE = 3'd3;
   localparam logic [2:0] KIND_DELETE     = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]              kind;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     hit;
      logic [1:0]               status;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   // operation broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_READ,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
   } cell_cmd_type;

endpackage

FILE: rtl/indexed_sequence_store.sv
// indexed sequence store: ordered list of signed 32-bit values in a row of shift cells
// an accepted request passes through S_EXEC and S_GATHER to the one-cycle rsp_strobe
// a new request is not taken while the block is busy in the execute then gather sequence
// a new request is taken in the cycle that the previous result is strobed
// reset clears the length and the control state; stored values are not cleared
// the receiver cannot stall: rsp_strobe marks each result for one cycle only; rsp_data holds it until the next
module indexed_sequence_store #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  isi_pkg::req_type req_data,
   output logic             rsp_strobe,
   output isi_pkg::rsp_type rsp_data
);
   import isi_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GATHER
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   req_type          req_ff;
   req_type          req_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             strobe_ff;
   logic             strobe_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [1:0]       status_ff;
   logic [1:0]       status_in;
   logic             hit_ff;
   logic             hit_in;

   cell_cmd_type             cmd;
   logic [POS_W-1:0]         count_pos;
   logic                     full;
   logic signed [DATA_W-1:0] gathered;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_tap   [CAPACITY];

   assign count_pos = POS_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   // row of cells, each shifting to or from its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      isi_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .tap         (cell_tap[i])
      );
   end

   // only the addressed cell drives a nonzero tap
   always_comb begin
      gathered = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         gathered = gathered | cell_tap[i];
      end
   end

   // request sequencing, range and full checks, and result capture
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      count_in  = count_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      cmd.op         = CELL_HOLD;
      cmd.position   = req_ff.position;
      cmd.item_value = req_ff.item_value;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_GATHER;
            status_in = STATUS_DONE;
            hit_in    = 1'b0;
            unique case (req_ff.kind)
               KIND_READ: begin
                  if (req_ff.position < count_pos) begin
                     cmd.op = CELL_READ;
                     hit_in = 1'b1;
                  end else begin
                     status_in = STATUS_RANGE;
                  end
               end
               KIND_INS_FRONT: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op       = CELL_INSERT;
                     cmd.position = '0;
                     count_in     = count_ff + CNT_W'(1);
                  end
               end
               KIND_APPEND: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op       = CELL_INSERT;
                     cmd.position = count_pos;
                     count_in     = count_ff + CNT_W'(1);
                  end
               end
               KIND_INS_BEFORE: begin
                  priority if (req_ff.position > count_pos) begin
                     status_in = STATUS_RANGE;
                  end else if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op   = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_DELETE: begin
                  if (req_ff.position < count_pos) begin
                     cmd.op   = CELL_DELETE;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = STATUS_RANGE;
                  end
               end
               default: begin
                  status_in = STATUS_RANGE;
               end
            endcase
         end
         S_GATHER: begin
            rsp_in.read_value = hit_ff ? gathered : '1;
            rsp_in.hit        = hit_ff;
            rsp_in.status     = status_ff;
            rsp_in.length     = LEN_W'(count_ff);
            strobe_in         = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: rtl/isi_cell.sv
module isi_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  isi_pkg::cell_cmd_type             cmd,
   input  logic signed [isi_pkg::DATA_W-1:0] left_value,
   input  logic signed [isi_pkg::DATA_W-1:0] right_value,
   output logic signed [isi_pkg::DATA_W-1:0] value,
   output logic signed [isi_pkg::DATA_W-1:0] tap
);
   import isi_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic signed [DATA_W-1:0] tap_ff;
   logic signed [DATA_W-1:0] tap_in;
   logic                     here;
   logic                     beyond;

   // position decode for this cell
   assign here   = (IDX == cmd.position);
   assign beyond = (IDX > cmd.position);

   // shift from a neighbor, take the new value, hold, or tap the value for a read
   always_comb begin
      value_in = value_ff;
      tap_in   = '0;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (beyond) begin
               value_in = left_value;
            end else if (here) begin
               value_in = cmd.item_value;
            end
         end
         CELL_DELETE: begin
            if (here || beyond) begin
               value_in = right_value;
            end
         end
         CELL_READ: begin
            if (here) begin
               tap_in = value_ff;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
   end

   assign value = value_ff;
   assign tap   = tap_ff;

endmodule

FILE: rtl/isi_checker.sv
`include "indexed_sequence_store_macros.svh"

module isi_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input isi_pkg::rsp_type rsp_data
);
   import isi_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // an accepted beat makes the block busy
   `ISI_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)

   // every accepted beat gives a result strobe
   `ISI_ASSERT_NOW(a_accept_result, clock, reset, accept, ##3 rsp_strobe)

   // results are single-cycle strobes
   `ISI_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // a hit is always a completed request
   `ISI_ASSERT_NOW(a_hit_done, clock, reset, rsp_strobe && rsp_data.hit,
      rsp_data.status == STATUS_DONE)

   // a result without a hit carries minus one
   `ISI_ASSERT_NOW(a_miss_value, clock, reset, rsp_strobe && !rsp_data.hit,
      rsp_data.read_value == -32'sd1)

endmodule

bind indexed_sequence_store isi_checker u_isi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
